/* rtl/yrp_pkg.sv */
`default_nettype none

package yrp_pkg;

	// Cycles from an accepted beat to its result strobe.
	localparam int unsigned PIPE_LATENCY = 6;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		REG_RED_MASK   = 2'd0,
		REG_GREEN_MASK = 2'd1,
		REG_BLUE_MASK  = 2'd2,
		REG_WIDE_MODE  = 2'd3
	} reg_index_t;

	// Selects which chroma term a table holds.
	typedef enum logic [1:0] {
		TERM_VR,
		TERM_UG,
		TERM_VG,
		TERM_UB
	} chroma_term_t;

	// Per-stage valid bits handed from the top level to the lanes.
	typedef struct packed {
		logic acc;
		logic s1;
		logic s2;
		logic s3;
		logic s4;
	} stage_vld_t;

	typedef logic [7:0]        luma_lut_t   [256];
	typedef logic signed [8:0] chroma_lut_t [256];

	// Luma clipped to 16..235 and stretched to 0..255, rounded half up.
	function automatic luma_lut_t build_luma_lut();
		luma_lut_t lut;
		longint    yc;
		longint    v;
		for (int i = 0; i < 256; i++) begin
			if (i < 16) begin
				yc = 16;
			end else if (i > 235) begin
				yc = 235;
			end else begin
				yc = longint'(i);
			end
			v = (510 * (yc - 16) + 219) / 438;
			lut[i] = v[7:0];
		end
		return lut;
	endfunction

	// Chroma clipped to 16..240, centered, and weighted; the division
	// truncates toward zero after adding one half.
	function automatic chroma_lut_t build_chroma_lut(input chroma_term_t sel);
		chroma_lut_t lut;
		longint      d;
		longint      v;
		for (int i = 0; i < 256; i++) begin
			if (i < 16) begin
				d = 16;
			end else if (i > 240) begin
				d = 240;
			end else begin
				d = longint'(i);
			end
			d = d - 128;
			unique case (sel)
				TERM_VR: v = (357510 * d + 112000) / 224000;
				TERM_UG: v = (-51512040 * d + 65744000) / 131488000;
				TERM_VG: v = (-106895490 * d + 65744000) / 131488000;
				TERM_UB: v = (451860 * d + 112000) / 224000;
			endcase
			lut[i] = v[8:0];
		end
		return lut;
	endfunction

	localparam luma_lut_t   Y_LUT  = build_luma_lut();
	localparam chroma_lut_t VR_LUT = build_chroma_lut(TERM_VR);
	localparam chroma_lut_t UG_LUT = build_chroma_lut(TERM_UG);
	localparam chroma_lut_t VG_LUT = build_chroma_lut(TERM_VG);
	localparam chroma_lut_t UB_LUT = build_chroma_lut(TERM_UB);

endpackage

`default_nettype wire

/* rtl/yrp_field_scale.sv */
`default_nettype none

module yrp_field_scale (
	input  wire logic               clk,
	input  wire yrp_pkg::stage_vld_t vld,
	input  wire logic [7:0]         chan,
	input  wire logic [31:0]        mask,
	output logic [31:0]             field
);
	import yrp_pkg::*;

	logic [39:0] prod_s3;
	logic [39:0] x_s4;
	logic [31:0] q_s4;
	logic [31:0] field_s5;
	logic [39:0] series_sum;
	logic [39:0] mult255;
	logic [39:0] rem;
	logic        round_up;

	// Channel times mask; the product stays below 2^40.
	always_ff @(posedge clk) begin
		if (vld.s2) begin
			prod_s3 <= {32'd0, chan} * {8'd0, mask};
		end
	end

	// Quotient estimate for x/255 from the series 1/256 + 1/256^2 + ...
	// It is exact or one short.
	assign series_sum = prod_s3 + (prod_s3 >> 8) + (prod_s3 >> 16)
	                  + (prod_s3 >> 24) + (prod_s3 >> 32);

	always_ff @(posedge clk) begin
		if (vld.s3) begin
			x_s4 <= prod_s3;
			q_s4 <= series_sum[39:8];
		end
	end

	// Correct the estimate by one when the remainder reaches 255.
	assign mult255  = {q_s4, 8'd0} - {8'd0, q_s4};
	assign rem      = x_s4 - mult255;
	assign round_up = (rem >= 40'd255);

	always_ff @(posedge clk) begin
		if (vld.s4) begin
			field_s5 <= (q_s4 + 32'(round_up)) & mask;
		end
	end

	assign field = field_s5;

`ifndef ASSERT_OFF
	// The series estimate is never more than one below the true quotient.
	a_rem_bound: assert property (@(posedge clk) vld.s4 |-> rem < 40'd510)
		else $error("field scale remainder out of range");
`endif

endmodule

`default_nettype wire

/* rtl/yrp_lane.sv */
`default_nettype none

module yrp_lane (
	input  wire logic                clk,
	input  wire yrp_pkg::stage_vld_t vld,
	input  wire logic [7:0]          luma,
	input  wire logic signed [8:0]   vr_s1,
	input  wire logic signed [8:0]   ug_s1,
	input  wire logic signed [8:0]   vg_s1,
	input  wire logic signed [8:0]   ub_s1,
	input  wire logic [31:0]         mask_red,
	input  wire logic [31:0]         mask_green,
	input  wire logic [31:0]         mask_blue,
	output logic [31:0]              word
);
	import yrp_pkg::*;

	logic [7:0]         yt_s1;
	logic signed [10:0] y_ext;
	logic signed [10:0] r_sum;
	logic signed [10:0] g_sum;
	logic signed [10:0] b_sum;
	logic [7:0]         r_s2;
	logic [7:0]         g_s2;
	logic [7:0]         b_s2;
	logic [31:0]        r_field;
	logic [31:0]        g_field;
	logic [31:0]        b_field;

	function automatic logic [7:0] clamp_u8(input logic signed [10:0] v);
		logic [7:0] res;
		if (v < 11'sd0) begin
			res = 8'd0;
		end else if (v > 11'sd255) begin
			res = 8'hFF;
		end else begin
			res = v[7:0];
		end
		return res;
	endfunction

	// Luma term lookup.
	always_ff @(posedge clk) begin
		if (vld.acc) begin
			yt_s1 <= Y_LUT[luma];
		end
	end

	// Channel sums, clamped to 0..255.
	assign y_ext = signed'({3'b000, yt_s1});
	assign r_sum = y_ext + 11'(vr_s1);
	assign g_sum = y_ext + 11'(ug_s1) + 11'(vg_s1);
	assign b_sum = y_ext + 11'(ub_s1);

	always_ff @(posedge clk) begin
		if (vld.s1) begin
			r_s2 <= clamp_u8(r_sum);
			g_s2 <= clamp_u8(g_sum);
			b_s2 <= clamp_u8(b_sum);
		end
	end

	// One scaler per channel.
	yrp_field_scale u_red (
		.clk   (clk),
		.vld   (vld),
		.chan  (r_s2),
		.mask  (mask_red),
		.field (r_field)
	);

	yrp_field_scale u_green (
		.clk   (clk),
		.vld   (vld),
		.chan  (g_s2),
		.mask  (mask_green),
		.field (g_field)
	);

	yrp_field_scale u_blue (
		.clk   (clk),
		.vld   (vld),
		.chan  (b_s2),
		.mask  (mask_blue),
		.field (b_field)
	);

	// Fields are ORed without priority.
	assign word = r_field | g_field | b_field;

endmodule

`default_nettype wire

/* rtl/ycbcr_to_packed_rgb_core.sv */
`default_nettype none

// A beat accepted at a clock edge reaches its result strobe (done) through the valid registers vld_s1 to vld_s6.
// Throughput: one pixel pair per clock while busy is low; six register stages, two pixel lanes side by side.
// The receiver cannot stall: done is high for one cycle per result, and the words hold until the next result.
// Reset (arst_n low) empties the pipeline and restores the mask and mode registers;
// busy is high for the first cycle after reset is released, low from then on.
module ycbcr_to_packed_rgb_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [7:0]  luma_first,
	input  wire logic [7:0]  luma_second,
	input  wire logic [7:0]  chroma_blue,
	input  wire logic [7:0]  chroma_red,
	output logic             done,
	output logic [31:0]      pixel_first,
	output logic [31:0]      pixel_second,
	input  wire logic        wr_en,
	input  wire logic [1:0]  wr_index,
	input  wire logic [31:0] wr_data
);
	import yrp_pkg::*;

	logic               busy_q;
	logic               accept;
	logic [31:0]        mask_red_q;
	logic [31:0]        mask_green_q;
	logic [31:0]        mask_blue_q;
	logic               wide_mode_q;
	logic               vld_s1;
	logic               vld_s2;
	logic               vld_s3;
	logic               vld_s4;
	logic               vld_s5;
	logic               vld_s6;
	stage_vld_t         vld;
	logic signed [8:0]  vr_s1;
	logic signed [8:0]  ug_s1;
	logic signed [8:0]  vg_s1;
	logic signed [8:0]  ub_s1;
	logic [31:0]        word_first;
	logic [31:0]        word_second;
	logic [31:0]        pixel_first_s6;
	logic [31:0]        pixel_second_s6;

	assign accept = start && !busy_q;
	assign busy   = busy_q;

	// Hold off the first cycle after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
		end else begin
			busy_q <= 1'b0;
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_red_q   <= 32'h00FF_0000;
			mask_green_q <= 32'h0000_FF00;
			mask_blue_q  <= 32'h0000_00FF;
			wide_mode_q  <= 1'b1;
		end else if (wr_en) begin
			unique case (reg_index_t'(wr_index))
				REG_RED_MASK:   mask_red_q   <= wr_data;
				REG_GREEN_MASK: mask_green_q <= wr_data;
				REG_BLUE_MASK:  mask_blue_q  <= wr_data;
				REG_WIDE_MODE:  wide_mode_q  <= wr_data[0];
			endcase
		end
	end

	// Valid bits that follow each beat down the pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else begin
			vld_s1 <= accept;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	assign vld = '{acc: accept, s1: vld_s1, s2: vld_s2, s3: vld_s3, s4: vld_s4};

	// Shared chroma terms, looked up once for both pixels.
	always_ff @(posedge clk) begin
		if (accept) begin
			vr_s1 <= VR_LUT[chroma_red];
			ug_s1 <= UG_LUT[chroma_blue];
			vg_s1 <= VG_LUT[chroma_red];
			ub_s1 <= UB_LUT[chroma_blue];
		end
	end

	yrp_lane u_lane_first (
		.clk        (clk),
		.vld        (vld),
		.luma       (luma_first),
		.vr_s1      (vr_s1),
		.ug_s1      (ug_s1),
		.vg_s1      (vg_s1),
		.ub_s1      (ub_s1),
		.mask_red   (mask_red_q),
		.mask_green (mask_green_q),
		.mask_blue  (mask_blue_q),
		.word       (word_first)
	);

	yrp_lane u_lane_second (
		.clk        (clk),
		.vld        (vld),
		.luma       (luma_second),
		.vr_s1      (vr_s1),
		.ug_s1      (ug_s1),
		.vg_s1      (vg_s1),
		.ub_s1      (ub_s1),
		.mask_red   (mask_red_q),
		.mask_green (mask_green_q),
		.mask_blue  (mask_blue_q),
		.word       (word_second)
	);

	// Register both lane words into the result registers; narrow mode keeps the low 16 bits.
	always_ff @(posedge clk) begin
		if (vld_s5) begin
			pixel_first_s6  <= wide_mode_q ? word_first  : {16'd0, word_first[15:0]};
			pixel_second_s6 <= wide_mode_q ? word_second : {16'd0, word_second[15:0]};
		end
	end

	assign done         = vld_s6;
	assign pixel_first  = pixel_first_s6;
	assign pixel_second = pixel_second_s6;

`ifndef ASSERT_OFF
	// Every result strobe traces back to an accepted beat.
	a_done_from_beat: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, PIPE_LATENCY))
		else $error("result strobe without a matching beat");

	// Narrow mode leaves the upper half of both words clear.
	a_narrow_upper: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !$past(wide_mode_q)) |->
		(pixel_first[31:16] == 16'd0 && pixel_second[31:16] == 16'd0))
		else $error("upper half set in narrow mode");

	// A high busy is always low again in the next cycle.
	a_busy_once: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> !busy)
		else $error("busy held longer than one cycle");
`endif

endmodule

`default_nettype wire

/* verif/ycbcr_to_packed_rgb_core_tb.sv */
`timescale 1ns / 1ps

module ycbcr_to_packed_rgb_core_tb;
	import yrp_pkg::*;

	typedef struct {
		logic [7:0] y0;
		logic [7:0] y1;
		logic [7:0] cb;
		logic [7:0] cr;
	} ycc_pair_t;

	typedef struct {
		ycc_pair_t  src;
		logic [31:0] first;
		logic [31:0] second;
	} rgb_pair_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [7:0]  luma_first = '0;
	logic [7:0]  luma_second = '0;
	logic [7:0]  chroma_blue = '0;
	logic [7:0]  chroma_red = '0;
	logic        done;
	logic [31:0] pixel_first;
	logic [31:0] pixel_second;
	logic        wr_en = 1'b0;
	logic [1:0]  wr_index = '0;
	logic [31:0] wr_data = '0;

	// Shadow copy of the mask and mode registers.
	logic [31:0] mask_red_q = 32'h00FF_0000;
	logic [31:0] mask_green_q = 32'h0000_FF00;
	logic [31:0] mask_blue_q = 32'h0000_00FF;
	logic        wide_mode_q = 1'b1;

	ycc_pair_t pending_pairs [$];
	rgb_pair_t expected_words [$];
	ycc_pair_t on_ports;
	int        idle_pct = 29;
	int        err_count = 0;

	ycbcr_to_packed_rgb_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.luma_first   (luma_first),
		.luma_second  (luma_second),
		.chroma_blue  (chroma_blue),
		.chroma_red   (chroma_red),
		.done         (done),
		.pixel_first  (pixel_first),
		.pixel_second (pixel_second),
		.wr_en        (wr_en),
		.wr_index     (wr_index),
		.wr_data      (wr_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Guard against a hung pipeline or a stuck handshake.
	initial begin
		#3_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	task automatic report_mismatch(input string msg);
		$display("MISMATCH @%0t: %s", $time, msg);
		err_count++;
	endtask

	// Half-up rounding of n/d with truncation toward zero, as the tables are built.
	function automatic longint round_half(input longint n, input longint d);
		return (2 * n + d) / (2 * d);
	endfunction

	function automatic longint clamp(input longint v, input longint lo, input longint hi);
		if (v < lo) begin
			return lo;
		end
		if (v > hi) begin
			return hi;
		end
		return v;
	endfunction

	// Scale a clamped 0..255 channel onto its field mask.
	function automatic logic [31:0] fit_channel(input longint c, input logic [31:0] mask);
		longint s;
		s = clamp(c, 0, 255) * longint'(mask);
		s = s / 255;
		return s[31:0] & mask;
	endfunction

	function automatic logic [31:0] pack_pixel(input logic [7:0] y, input longint vr,
			input longint ug, input longint vg, input longint ub);
		longint      yt;
		logic [31:0] w;
		yt = round_half((clamp(longint'(y), 16, 235) - 16) * 255, 219);
		w = fit_channel(yt + vr, mask_red_q)
			| fit_channel(yt + ug + vg, mask_green_q)
			| fit_channel(yt + ub, mask_blue_q);
		if (!wide_mode_q) begin
			w = w & 32'h0000_FFFF;
		end
		return w;
	endfunction

	// Expected pair of display words for one accepted beat.
	function automatic rgb_pair_t convert_pair(input ycc_pair_t p);
		rgb_pair_t r;
		longint    du;
		longint    dv;
		longint    vr;
		longint    ug;
		longint    vg;
		longint    ub;
		du = clamp(longint'(p.cb), 16, 240) - 128;
		dv = clamp(longint'(p.cr), 16, 240) - 128;
		vr = round_half(178755 * dv, 112000);
		ug = round_half(-25756020 * du, 65744000);
		vg = round_half(-53447745 * dv, 65744000);
		ub = round_half(225930 * du, 112000);
		r.src = p;
		r.first = pack_pixel(p.y0, vr, ug, vg, ub);
		r.second = pack_pixel(p.y1, vr, ug, vg, ub);
		return r;
	endfunction

	// Driver: predicts each accepted beat, then presents the next pair or idles.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (start && !busy) begin
				expected_words.push_back(convert_pair(on_ports));
			end
			if (start && busy) begin
				// Hold the beat until the core takes it.
			end else if (pending_pairs.size() != 0 && $urandom_range(99) >= idle_pct) begin
				on_ports = pending_pairs.pop_front();
				start <= 1'b1;
				luma_first <= on_ports.y0;
				luma_second <= on_ports.y1;
				chroma_blue <= on_ports.cb;
				chroma_red <= on_ports.cr;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// Monitor: every strobed result is checked against the oldest prediction.
	always @(posedge clk) begin
		rgb_pair_t want;
		if (arst_n && done) begin
			if (expected_words.size() == 0) begin
				report_mismatch($sformatf("unexpected result %h %h", pixel_first,
					pixel_second));
			end else begin
				want = expected_words.pop_front();
				if (pixel_first !== want.first) begin
					report_mismatch($sformatf("pixel_first %h, want %h (y=%h cb=%h cr=%h)",
						pixel_first, want.first, want.src.y0, want.src.cb, want.src.cr));
				end
				if (pixel_second !== want.second) begin
					report_mismatch($sformatf("pixel_second %h, want %h (y=%h cb=%h cr=%h)",
						pixel_second, want.second, want.src.y1, want.src.cb, want.src.cr));
				end
			end
		end
	end

	task automatic write_reg(input reg_index_t idx, input logic [31:0] value);
		@(posedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= value;
		case (idx)
			REG_RED_MASK: mask_red_q = value;
			REG_GREEN_MASK: mask_green_q = value;
			REG_BLUE_MASK: mask_blue_q = value;
			REG_WIDE_MODE: wide_mode_q = value[0];
		endcase
		@(posedge clk);
		wr_en <= 1'b0;
	endtask

	task automatic set_masks(input logic [31:0] r, input logic [31:0] g,
			input logic [31:0] b, input logic wide);
		write_reg(REG_RED_MASK, r);
		write_reg(REG_GREEN_MASK, g);
		write_reg(REG_BLUE_MASK, b);
		// Only bit 0 of the mode register exists; the rest is noise.
		write_reg(REG_WIDE_MODE, {31'($urandom_range(32'h7FFF_FFFF)), wide});
	endtask

	task automatic queue_pair(input logic [7:0] y0, input logic [7:0] y1,
			input logic [7:0] cb, input logic [7:0] cr);
		ycc_pair_t p;
		p.y0 = y0;
		p.y1 = y1;
		p.cb = cb;
		p.cr = cr;
		pending_pairs.push_back(p);
	endtask

	// Mostly full-range samples, the rest near the clipping limits, at the extremes or at 128.
	function automatic logic [7:0] pick_sample();
		if ($urandom_range(99) < 65) begin
			return 8'($urandom_range(255));
		end
		case ($urandom_range(11))
			0: return 8'd0;
			1: return 8'd15;
			2: return 8'd16;
			3: return 8'd17;
			4: return 8'd128;
			5: return 8'd234;
			6: return 8'd235;
			7: return 8'd236;
			8: return 8'd239;
			9: return 8'd240;
			10: return 8'd241;
			default: return 8'd255;
		endcase
	endfunction

	// A random mask: either any bits at all or one contiguous field.
	function automatic logic [31:0] pick_mask();
		int lo;
		int len;
		if ($urandom_range(1) == 0) begin
			return $urandom;
		end
		lo = $urandom_range(31);
		len = $urandom_range(32);
		return 32'((64'd1 << len) - 1) << lo;
	endfunction

	// Wait until every queued beat is taken and every result is back.
	task automatic drain_results();
		int waited;
		waited = 0;
		while ((pending_pairs.size() != 0 || start || expected_words.size() != 0)
				&& waited < 20000) begin
			@(negedge clk);
			waited++;
		end
		if (pending_pairs.size() != 0 || start) begin
			report_mismatch($sformatf("%0d beats never accepted", pending_pairs.size()));
			pending_pairs.delete();
		end
		if (expected_words.size() != 0) begin
			report_mismatch($sformatf("%0d results never arrived", expected_words.size()));
			expected_words.delete();
		end
		repeat (PIPE_LATENCY + 2) @(negedge clk);
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed pairs under the reset register values: sample extremes,
		// clipping limits, neutral chroma and channel overflow both ways.
		queue_pair(8'd0, 8'd255, 8'd0, 8'd0);
		queue_pair(8'd255, 8'd0, 8'd255, 8'd255);
		queue_pair(8'd16, 8'd235, 8'd128, 8'd128);
		queue_pair(8'd15, 8'd236, 8'd15, 8'd241);
		queue_pair(8'd17, 8'd234, 8'd16, 8'd240);
		queue_pair(8'd235, 8'd235, 8'd128, 8'd240);
		queue_pair(8'd16, 8'd16, 8'd16, 8'd128);
		queue_pair(8'd235, 8'd16, 8'd240, 8'd16);
		queue_pair(8'd128, 8'd128, 8'd0, 8'd255);
		queue_pair(8'd255, 8'd255, 8'd255, 8'd0);
		queue_pair(8'd0, 8'd0, 8'd128, 8'd128);
		queue_pair(8'd100, 8'd200, 8'd90, 8'd170);
		queue_pair(8'd81, 8'd145, 8'd90, 8'd240);
		queue_pair(8'hAA, 8'h55, 8'h55, 8'hAA);
		drain_results();

		// Fully overlapping masks, then narrow words with directed pairs.
		set_masks(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
		queue_pair(8'd0, 8'd255, 8'd0, 8'd255);
		queue_pair(8'd235, 8'd16, 8'd240, 8'd16);
		drain_results();
		set_masks(32'h0000_F800, 32'h0000_07E0, 32'h0000_001F, 1'b0);
		queue_pair(8'd235, 8'd16, 8'd128, 8'd128);
		queue_pair(8'd255, 8'd0, 8'd0, 8'd255);
		drain_results();

		// Random phases, each with its own register setting.
		for (int ph = 0; ph < 9; ph++) begin
			if (ph < 3) begin
				idle_pct = 29;
			end else if (ph < 6) begin
				idle_pct = 50;
			end else begin
				idle_pct = 0;
			end
			case (ph)
				0: set_masks(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
				1: set_masks(32'h0, 32'h0, 32'h0, 1'b0);
				2: set_masks(32'h0000_F800, 32'h0000_07E0, 32'h0000_001F, 1'b0);
				3: set_masks(pick_mask(), pick_mask(), pick_mask(), 1'($urandom_range(1)));
				4: set_masks(32'hFF00_0000, 32'h00FF_0000, 32'h0000_FFFF, 1'b0);
				5: set_masks(pick_mask(), pick_mask(), pick_mask(), 1'b1);
				6: set_masks(32'h00FF_0000, 32'h0000_FF00, 32'h0000_00FF, 1'b1);
				7: set_masks(pick_mask(), 32'h0, pick_mask(), 1'b0);
				default: set_masks(32'h0000_7C00, 32'h0000_03E0, 32'h8000_001F, 1'b1);
			endcase
			for (int i = 0; i < 100; i++) begin
				queue_pair(pick_sample(), pick_sample(), pick_sample(), pick_sample());
			end
			drain_results();
		end

		repeat (PIPE_LATENCY + 4) @(posedge clk);
		if (err_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
